>>> hw/rtl/rrs_pkg.sv
// Shared types and codes for the rotor relay sequencer.
// Used by rrs_seq, rrs_preset and rotor_relay_sequencer_with_preset.
package rrs_pkg;

  // request types
  localparam logic [2:0] REQ_ROTOR_CMD   = 3'd0;
  localparam logic [2:0] REQ_PRESET_MODE = 3'd1;
  localparam logic [2:0] REQ_HEADING     = 3'd2;
  localparam logic [2:0] REQ_SEQ_STEP    = 3'd3;
  localparam logic [2:0] REQ_PRESET_TICK = 3'd4;

  // rotor commands
  localparam logic [2:0] CMD_NONE      = 3'd0;
  localparam logic [2:0] CMD_STOP      = 3'd1;
  localparam logic [2:0] CMD_CW        = 3'd2;
  localparam logic [2:0] CMD_CCW       = 3'd3;
  localparam logic [2:0] CMD_FAST_STOP = 3'd4;

  // preset modes
  localparam logic [2:0] PM_NONE = 3'd0;
  localparam logic [2:0] PM_STOP = 3'd1;
  localparam logic [2:0] PM_EXEC = 3'd2;
  localparam logic [2:0] PM_CW   = 3'd3;
  localparam logic [2:0] PM_CCW  = 3'd4;

  // relay actions
  localparam logic [3:0] ACT_NONE       = 4'd0;
  localparam logic [3:0] ACT_POWER_ON   = 4'd1;
  localparam logic [3:0] ACT_BRAKE_REL  = 4'd2;
  localparam logic [3:0] ACT_ROT_CW     = 4'd3;
  localparam logic [3:0] ACT_ROT_CCW    = 4'd4;
  localparam logic [3:0] ACT_ROTOR_OFF  = 4'd5;
  localparam logic [3:0] ACT_BRAKE_LOCK = 4'd6;
  localparam logic [3:0] ACT_POWER_OFF  = 4'd7;
  localparam logic [3:0] ACT_FAST_STOP  = 4'd8;

  // sequencer states
  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_REL_BRAKE  = 3'd1;
  localparam logic [2:0] ST_RAMPUP     = 3'd2;
  localparam logic [2:0] ST_TURN_CW    = 3'd3;
  localparam logic [2:0] ST_TURN_CCW   = 3'd4;
  localparam logic [2:0] ST_LOCK_BRAKE = 3'd5;
  localparam logic [2:0] ST_RAMPDOWN   = 3'd6;

  // busy wait loads
  localparam logic [3:0] BUSY_LONG  = 4'd10;
  localparam logic [3:0] BUSY_SHORT = 4'd5;

  typedef struct packed {
    logic [2:0] state;
    logic [2:0] pending;
    logic       busy;
    logic [3:0] busy_load;
  } rrs_seq_t;

  typedef struct packed {
    logic [8:0] target;
    logic [2:0] mode;
    logic [5:0] countdown;
    logic [5:0] reload;
    logic [7:0] hold;
  } rrs_preset_t;

endpackage

>>> hw/rtl/rrs_seq.sv
// Relay sequencer next-state logic for one sequencer step request.
// Depends on rrs_pkg.
module rrs_seq (
  input  rrs_pkg::rrs_seq_t cur,
  output rrs_pkg::rrs_seq_t nxt,
  output logic [3:0]        action,
  output logic              fast_stop
);

  logic       turn_req;
  logic [2:0] turn_state;
  logic [3:0] turn_action;

  assign turn_req    = (cur.pending == rrs_pkg::CMD_CW) || (cur.pending == rrs_pkg::CMD_CCW);
  assign turn_state  = (cur.pending == rrs_pkg::CMD_CW) ? rrs_pkg::ST_TURN_CW
                                                        : rrs_pkg::ST_TURN_CCW;
  assign turn_action = (cur.pending == rrs_pkg::CMD_CW) ? rrs_pkg::ACT_ROT_CW
                                                        : rrs_pkg::ACT_ROT_CCW;

  always_comb begin
    nxt       = cur;
    action    = rrs_pkg::ACT_NONE;
    fast_stop = 1'b0;
    if (cur.pending == rrs_pkg::CMD_STOP) begin
      nxt.busy = 1'b1;
      case (cur.state)
        rrs_pkg::ST_REL_BRAKE, rrs_pkg::ST_TURN_CW, rrs_pkg::ST_TURN_CCW: begin
          action        = rrs_pkg::ACT_ROTOR_OFF;
          nxt.busy_load = rrs_pkg::BUSY_SHORT;
          nxt.state     = rrs_pkg::ST_LOCK_BRAKE;
        end
        rrs_pkg::ST_RAMPUP, rrs_pkg::ST_LOCK_BRAKE: begin
          action        = rrs_pkg::ACT_BRAKE_LOCK;
          nxt.busy_load = rrs_pkg::BUSY_SHORT;
          nxt.state     = rrs_pkg::ST_RAMPDOWN;
        end
        rrs_pkg::ST_RAMPDOWN: begin
          action        = rrs_pkg::ACT_POWER_OFF;
          nxt.busy_load = rrs_pkg::BUSY_LONG;
          nxt.state     = rrs_pkg::ST_IDLE;
        end
        rrs_pkg::ST_IDLE: begin
          nxt.pending = rrs_pkg::CMD_NONE;
          nxt.busy    = 1'b0;
        end
        default: begin
        end
      endcase
    end else if (turn_req) begin
      nxt.busy = 1'b1;
      if (cur.state == rrs_pkg::ST_IDLE) begin
        action        = rrs_pkg::ACT_POWER_ON;
        nxt.state     = rrs_pkg::ST_REL_BRAKE;
        nxt.busy_load = rrs_pkg::BUSY_LONG;
      end else if (cur.state == rrs_pkg::ST_REL_BRAKE) begin
        action        = rrs_pkg::ACT_BRAKE_REL;
        nxt.state     = rrs_pkg::ST_RAMPUP;
        nxt.busy_load = rrs_pkg::BUSY_SHORT;
      end else if (cur.state == rrs_pkg::ST_RAMPUP) begin
        action        = turn_action;
        nxt.state     = turn_state;
        nxt.busy_load = rrs_pkg::BUSY_SHORT;
      end else if (cur.state == turn_state) begin
        nxt.pending = rrs_pkg::CMD_NONE;
      end
      // wrong direction or unwinding: only busy is raised
    end else if (cur.pending == rrs_pkg::CMD_FAST_STOP) begin
      action      = rrs_pkg::ACT_FAST_STOP;
      fast_stop   = 1'b1;
      nxt.state   = rrs_pkg::ST_IDLE;
      nxt.pending = rrs_pkg::CMD_NONE;
      nxt.busy    = 1'b0;
    end
  end

endmodule

>>> hw/rtl/rrs_preset.sv
// Preset heading stepper: next state for one preset tick.
// Depends on rrs_pkg.
module rrs_preset #(
  parameter int RELOAD_MAX = 32,
  parameter int RELOAD_MIN = 4,
  parameter int HOLD_LIMIT = 200
) (
  input  rrs_pkg::rrs_preset_t cur,
  input  logic [8:0]           angle_hi,
  input  logic [8:0]           angle_lo,
  output rrs_pkg::rrs_preset_t nxt
);

  logic [5:0] reload_upd;
  logic [7:0] hold_upd;

  always_comb begin
    nxt        = cur;
    reload_upd = cur.reload;
    hold_upd   = cur.hold;
    if (cur.mode == rrs_pkg::PM_NONE) begin
      nxt = cur;
    end else if (cur.mode == rrs_pkg::PM_STOP) begin
      nxt.countdown = 6'd0;
      nxt.hold      = 8'd0;
      nxt.reload    = 6'(RELOAD_MAX);
      nxt.mode      = rrs_pkg::PM_EXEC;
    end else begin
      // interval halves, while above RELOAD_MIN, each time the hold counter runs past its limit
      if (cur.hold > 8'(HOLD_LIMIT)) begin
        hold_upd = 8'd0;
        if (cur.reload > 6'(RELOAD_MIN)) begin
          reload_upd = cur.reload >> 1;
        end
      end
      nxt.hold   = hold_upd + 8'd1;
      nxt.reload = reload_upd;
      if (cur.countdown != 6'd0) begin
        nxt.countdown = cur.countdown - 6'd1;
      end else begin
        if (cur.mode == rrs_pkg::PM_CW) begin
          nxt.target = (cur.target >= angle_hi) ? angle_lo : cur.target + 9'd1;
        end else if (cur.mode == rrs_pkg::PM_CCW) begin
          nxt.target = (cur.target <= angle_lo) ? angle_hi : cur.target - 9'd1;
        end
        nxt.countdown = reload_upd;
      end
    end
  end

endmodule

>>> hw/rtl/rotor_relay_sequencer_with_preset.sv
// Rotator relay sequencer with preset heading stepper, top level; uses rrs_pkg, rrs_seq, rrs_preset.
// A request is held in the input stage registers and is then passed through the
// next-state logic into the result registers. Throughput: one request per cycle while out_stall
// is low, set by the combinational next-state logic between the input and result registers.
// Reset (rst_n low, synchronous): sequencer idle, preset tracking cleared, angle limits
// 360 and 0, both register stages empty.
module rotor_relay_sequencer_with_preset #(
  parameter int RELOAD_MAX = 32,
  parameter int RELOAD_MIN = 4,
  parameter int HOLD_LIMIT = 200
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_req_type,
  input  logic [2:0] in_command,
  input  logic [8:0] in_heading,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_action,
  output logic [2:0] out_rotor_state,
  output logic       out_busy_res,
  output logic [3:0] out_busy_count,
  output logic [8:0] out_preset_heading,
  output logic [2:0] out_last_command,
  output logic [2:0] out_preset_mode
);

  localparam logic CFG_ANGLE_HI = 1'b0;
  localparam logic CFG_ANGLE_LO = 1'b1;

  logic [8:0] angle_hi_r;
  logic [8:0] angle_lo_r;

  // input stage
  logic       req_valid_r;
  logic [2:0] req_type_r;
  logic [2:0] req_cmd_r;
  logic [8:0] req_heading_r;

  // block state
  rrs_pkg::rrs_seq_t    seq_r, seq_nxt, seq_step;
  rrs_pkg::rrs_preset_t preset_r, preset_nxt, preset_tick;
  logic [2:0]           prior_r, prior_nxt;
  logic [8:0]           measured_r, measured_nxt;

  logic [3:0] step_action;
  logic       step_fast_stop;
  logic [3:0] action_nxt;

  logic out_valid_r;
  logic advance;
  logic in_take;

  assign advance  = req_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = req_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_hi_r <= 9'd360;
      angle_lo_r <= 9'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ANGLE_HI: angle_hi_r <= cfg_data;
        CFG_ANGLE_LO: angle_lo_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_take) begin
      req_valid_r <= 1'b1;
    end else if (advance) begin
      req_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_type_r    <= in_req_type;
      req_cmd_r     <= in_command;
      req_heading_r <= in_heading;
    end
  end

  rrs_seq u_seq (
    .cur       (seq_r),
    .nxt       (seq_step),
    .action    (step_action),
    .fast_stop (step_fast_stop)
  );

  rrs_preset #(
    .RELOAD_MAX (RELOAD_MAX),
    .RELOAD_MIN (RELOAD_MIN),
    .HOLD_LIMIT (HOLD_LIMIT)
  ) u_preset (
    .cur      (preset_r),
    .angle_hi (angle_hi_r),
    .angle_lo (angle_lo_r),
    .nxt      (preset_tick)
  );

  always_comb begin
    seq_nxt      = seq_r;
    preset_nxt   = preset_r;
    prior_nxt    = prior_r;
    measured_nxt = measured_r;
    action_nxt   = rrs_pkg::ACT_NONE;
    case (req_type_r)
      rrs_pkg::REQ_ROTOR_CMD: begin
        prior_nxt       = seq_r.pending;
        seq_nxt.pending = req_cmd_r;
      end
      rrs_pkg::REQ_PRESET_MODE: begin
        preset_nxt.mode = req_cmd_r;
      end
      rrs_pkg::REQ_HEADING: begin
        measured_nxt = req_heading_r;
        if (preset_r.mode == rrs_pkg::PM_NONE) begin
          preset_nxt.target = req_heading_r;
        end
      end
      rrs_pkg::REQ_SEQ_STEP: begin
        seq_nxt    = seq_step;
        action_nxt = step_action;
        if (step_fast_stop) begin
          // fast stop also drops preset tracking
          preset_nxt.target    = measured_r;
          preset_nxt.countdown = 6'd0;
          preset_nxt.mode      = rrs_pkg::PM_NONE;
        end
      end
      rrs_pkg::REQ_PRESET_TICK: begin
        preset_nxt = preset_tick;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r              <= '0;
      preset_r.target    <= 9'd0;
      preset_r.mode      <= rrs_pkg::PM_NONE;
      preset_r.countdown <= 6'd0;
      preset_r.reload    <= 6'(RELOAD_MAX);
      preset_r.hold      <= 8'd0;
      prior_r            <= rrs_pkg::CMD_NONE;
      measured_r         <= 9'd0;
    end else if (advance) begin
      seq_r      <= seq_nxt;
      preset_r   <= preset_nxt;
      prior_r    <= prior_nxt;
      measured_r <= measured_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_action         <= action_nxt;
      out_rotor_state    <= seq_nxt.state;
      out_busy_res       <= seq_nxt.busy;
      out_busy_count     <= seq_nxt.busy_load;
      out_preset_heading <= preset_nxt.target;
      out_last_command   <= prior_nxt;
      out_preset_mode    <= preset_nxt.mode;
    end
  end

  // a fast stop result always leaves the sequencer idle and preset off
  a_fast_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_action == rrs_pkg::ACT_FAST_STOP) |->
      (out_rotor_state == rrs_pkg::ST_IDLE && !out_busy_res &&
       out_preset_mode == rrs_pkg::PM_NONE))
    else $error("fast stop result not idle");

  // a request in the input stage moves on whenever the result slot frees
  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid_r && (!out_valid_r || !out_stall)) |=> out_valid_r)
    else $error("request stuck in input stage");

  // the reload interval never halves down to zero
  a_reload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    preset_r.reload != 6'd0)
    else $error("preset reload interval is zero");

  // state only changes when a request moves through
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(seq_r) && $stable(preset_r)))
    else $error("state changed without a request");

endmodule
